### src/assert_macros.svh
// Assertion helpers shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### src/lpbs_pkg.sv
package lpbs_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_HEADER = 2'd1,
    OP_EVAL   = 2'd2,
    OP_IDLE   = 2'd3
  } op_t;

  localparam int TIME_W     = 48;
  localparam int RATE_W     = 16;
  localparam int HALF_T_W   = TIME_W / 2;
  localparam int PROD_W     = HALF_T_W + RATE_W;
  localparam int FRAME_W    = 40;
  localparam int FRAC_W     = 8;
  localparam int DIGIT_W    = 8;
  localparam int MOD_STAGES = FRAME_W / DIGIT_W;
  localparam int LETTER_W   = 5;
  localparam int MIX_W      = 13;
  localparam int MOD_W      = 18;

  localparam logic [7:0]         CHAR_A     = 8'h61;
  localparam logic [7:0]         CHAR_Z     = 8'h7A;
  localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;
  localparam logic [MOD_W-1:0]   LEVEL_ONE  = 18'd65536;
  localparam logic [MOD_W-1:0]   LEVEL_STEP = 18'd22;
  localparam logic [MOD_W-1:0]   LEVEL_PEAK = 18'd140800;

endpackage

### src/lpbs_if.sv
interface lpbs_in_if;
  import lpbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [7:0]          style;
  logic [5:0]          position;
  logic [7:0]          letter;
  logic [6:0]          pattern_length;
  logic [RATE_W-1:0]   frame_rate;
  logic                blend;
  logic [TIME_W-1:0]   time_req;

  modport source (output valid, op, style, position, letter, pattern_length,
                  frame_rate, blend, time_req, input ready);
  modport sink   (input valid, op, style, position, letter, pattern_length,
                  frame_rate, blend, time_req, output ready);
endinterface

interface lpbs_out_if;
  import lpbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [MOD_W-1:0]  modifier;

  modport source (output valid, modifier, input ready);
  modport sink   (input valid, modifier, output ready);
endinterface

### src/light_pattern_brightness_sequencer.sv
// Light style brightness sequencer. Items carry an op: write one pattern letter,
// set a style header (length, Q8.8 frame rate, blend flag), or evaluate a style
// at a time in 1/65536 s, which returns one brightness modifier (65536 = 1.0).
// Writes, header updates and idle items return nothing. The block is a 12-stage
// pipeline that takes one item per clock unless a stall has backed up to its
// input; the depth comes from the split 48x16 frame multiply, five 8-bit digit
// stages of the frame-modulo-length reduction, and the registered read of the
// letter store. Stalls back up only as far as the first empty stage. Pattern
// letters read before they are written return undefined levels; header state
// resets to empty styles.
module light_pattern_brightness_sequencer #(
  parameter int STYLE_COUNT = 16,
  parameter int PATTERN_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lpbs_in_if.sink     in_item,
  lpbs_out_if.source  out_item
);
  import lpbs_pkg::*;

  `include "assert_macros.svh"

  localparam int SI_W   = (STYLE_COUNT > 1) ? $clog2(STYLE_COUNT) : 1;
  localparam int POS_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int DEPTH  = STYLE_COUNT * PATTERN_MAX;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int MUL_ST  = 1;
  localparam int FRM_ST  = 2;
  localparam int MOD0    = 3;
  localparam int MODL    = MOD0 + MOD_STAGES - 1;
  localparam int ADDR_ST = MODL + 1;
  localparam int MEM_ST  = ADDR_ST + 1;
  localparam int MIX_ST  = MEM_ST + 1;
  localparam int OUT_ST  = MIX_ST + 1;
  localparam int NST     = OUT_ST + 1;

  localparam logic [ADDR_W-1:0] PMAX_A  = ADDR_W'(PATTERN_MAX);
  localparam logic [8:0]        PMAX_9  = 9'(PATTERN_MAX);
  localparam logic [8:0]        SCNT_9  = 9'(STYLE_COUNT);

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [RATE_W-1:0] rate;
    logic              blend;
  } hdr_t;

  typedef struct packed {
    op_t                 op;
    logic                hit;
    logic                wr_ok;
    logic                hdr_ok;
    logic [SI_W-1:0]     sidx;
    logic [POS_W-1:0]    pos_in;
    logic [LETTER_W-1:0] lidx;
    logic [TIME_W-1:0]   tm;
    logic [LEN_W-1:0]    len;
    logic                blend;
    logic                special;
    logic [PROD_W-1:0]   p_hi;
    logic [PROD_W-1:0]   p_lo;
    logic [FRAME_W-1:0]  frame;
    logic [FRAC_W-1:0]   frac;
    logic [LEN_W-1:0]    rem;
    logic [ADDR_W-1:0]   addr0;
    logic [ADDR_W-1:0]   addr1;
    logic [MIX_W-1:0]    mix;
    logic [MOD_W-1:0]    modifier;
  } item_t;

  item_t                st_r   [NST];
  item_t                st_nxt [NST];
  logic [NST-1:0]       vld_r;
  logic [NST-1:0]       vld_nxt;
  logic [NST-1:0]       stage_free;
  logic [STYLE_COUNT-1:0] hv_r;
  hdr_t                 hdr_mem [STYLE_COUNT];
  hdr_t                 hdr_rd_r;
  logic [LETTER_W-1:0]  lvl_mem [DEPTH];
  logic [LETTER_W-1:0]  rd0_r;
  logic [LETTER_W-1:0]  rd1_r;
  logic                 in_fire;
  logic [SI_W-1:0]      in_sidx;
  logic                 in_hit;
  logic [8:0]           len_sat;

  // One remainder digit step per frame bit, eight bits per stage.
  function automatic logic [LEN_W-1:0] mod_digit(input logic [LEN_W-1:0]   rem,
                                                 input logic [DIGIT_W-1:0] bits,
                                                 input logic [LEN_W-1:0]   len);
    logic [LEN_W:0] acc;
    logic [LEN_W-1:0] r;
    r = rem;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      acc = {r, bits[b]};
      if (acc >= {1'b0, len}) begin
        acc = acc - {1'b0, len};
      end
      r = acc[LEN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] clamp_letter(input logic [7:0] ch);
    logic [7:0] d;
    d = ch - CHAR_A;
    if (ch < CHAR_A) begin
      return '0;
    end else if (ch > CHAR_Z) begin
      return LETTER_MAX;
    end
    return d[LETTER_W-1:0];
  endfunction

  assign in_fire = in_item.valid && stage_free[0];
  assign in_sidx = SI_W'(in_item.style);
  assign in_hit  = {1'b0, in_item.style} < SCNT_9;
  assign len_sat = ({2'b0, in_item.pattern_length} > PMAX_9) ? PMAX_9
                                                             : {2'b0, in_item.pattern_length};

  // A stage may load when it is empty or its item moves on.
  always_comb begin
    stage_free[NST-1] = !vld_r[NST-1] || out_item.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      stage_free[i] = !vld_r[i] || stage_free[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = in_item.valid;
    for (int i = 1; i < NST; i++) begin
      vld_nxt[i] = vld_r[i-1];
    end
    // Only evaluate items go past the letter store.
    vld_nxt[MIX_ST] = vld_r[MEM_ST] && (st_r[MEM_ST].op == OP_EVAL);
  end

  always_comb begin
    logic [LEN_W-1:0]    len;
    logic [LEN_W:0]      nxt_pos;
    logic [POS_W-1:0]    pos0;
    logic [POS_W-1:0]    pos1;
    logic [ADDR_W-1:0]   base;
    logic [FRAC_W-1:0]   fe;
    logic [MIX_W:0]      w0;
    logic [MIX_W:0]      w1;

    st_nxt[0]        = st_r[0];
    st_nxt[0].op     = op_t'(in_item.op);
    st_nxt[0].hit    = in_hit;
    st_nxt[0].wr_ok  = in_hit && ({3'b0, in_item.position} < PMAX_9);
    st_nxt[0].hdr_ok = hv_r[in_sidx];
    st_nxt[0].sidx   = in_sidx;
    st_nxt[0].pos_in = POS_W'(in_item.position);
    st_nxt[0].lidx   = clamp_letter(in_item.letter);
    st_nxt[0].tm     = in_item.time_req;
    for (int i = 1; i < NST; i++) begin
      st_nxt[i] = st_r[i-1];
    end

    // Header lookup and split frame multiply.
    len = st_r[0].hdr_ok ? hdr_rd_r.len : '0;
    st_nxt[MUL_ST].len     = len;
    st_nxt[MUL_ST].blend   = st_r[0].hdr_ok && hdr_rd_r.blend;
    st_nxt[MUL_ST].special = !st_r[0].hit || (len == '0);
    st_nxt[MUL_ST].p_hi    = {{RATE_W{1'b0}}, st_r[0].tm[TIME_W-1:HALF_T_W]}
                             * {{HALF_T_W{1'b0}}, (st_r[0].hdr_ok ? hdr_rd_r.rate : '0)};
    st_nxt[MUL_ST].p_lo    = {{RATE_W{1'b0}}, st_r[0].tm[HALF_T_W-1:0]}
                             * {{HALF_T_W{1'b0}}, (st_r[0].hdr_ok ? hdr_rd_r.rate : '0)};

    // Integer frame is product >> 24, fraction is product bits 23..16.
    st_nxt[FRM_ST].frame = st_r[MUL_ST].p_hi
                           + {{(PROD_W-RATE_W){1'b0}}, st_r[MUL_ST].p_lo[PROD_W-1:HALF_T_W]};
    st_nxt[FRM_ST].frac  = st_r[MUL_ST].p_lo[HALF_T_W-1 -: FRAC_W];
    st_nxt[FRM_ST].rem   = '0;

    for (int k = 0; k < MOD_STAGES; k++) begin
      st_nxt[MOD0+k].rem = mod_digit(st_r[MOD0+k-1].rem,
                                     st_r[MOD0+k-1].frame[FRAME_W-1-DIGIT_W*k -: DIGIT_W],
                                     st_r[MOD0+k-1].len);
    end

    // Letter addresses; the next letter wraps to the pattern start.
    nxt_pos = {1'b0, st_r[MODL].rem} + (LEN_W+1)'(1);
    pos0    = POS_W'(st_r[MODL].rem);
    pos1    = (nxt_pos == {1'b0, st_r[MODL].len}) ? '0 : POS_W'(nxt_pos);
    base    = ADDR_W'(st_r[MODL].sidx) * PMAX_A;
    st_nxt[ADDR_ST].addr0 = base + ADDR_W'((st_r[MODL].op == OP_WRITE) ? st_r[MODL].pos_in
                                                                        : pos0);
    st_nxt[ADDR_ST].addr1 = base + ADDR_W'(pos1);

    fe = st_r[MEM_ST].blend ? st_r[MEM_ST].frac : '0;
    w0 = (MIX_W+1)'(rd0_r) * ((MIX_W+1)'(256) - (MIX_W+1)'(fe));
    w1 = (MIX_W+1)'(rd1_r) * (MIX_W+1)'(fe);
    st_nxt[MIX_ST].mix = MIX_W'(w0 + w1);

    st_nxt[OUT_ST].modifier = st_r[MIX_ST].special ? LEVEL_ONE
                                                   : MOD_W'(st_r[MIX_ST].mix) * LEVEL_STEP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hv_r  <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (stage_free[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
      if (in_fire && (op_t'(in_item.op) == OP_HEADER) && in_hit) begin
        hv_r[in_sidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (stage_free[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Header store: written and read at accept, so items see headers in order.
  always_ff @(posedge clk) begin
    if (in_fire && (op_t'(in_item.op) == OP_HEADER) && in_hit) begin
      hdr_mem[in_sidx] <= '{len:   LEN_W'(len_sat),
                            rate:  in_item.frame_rate,
                            blend: in_item.blend};
    end
    if (stage_free[0]) begin
      hdr_rd_r <= hdr_mem[in_sidx];
    end
  end

  // Letter store: writes and reads share one stage to keep item order.
  always_ff @(posedge clk) begin
    if (stage_free[MEM_ST]) begin
      if (vld_r[ADDR_ST] && (st_r[ADDR_ST].op == OP_WRITE) && st_r[ADDR_ST].wr_ok) begin
        lvl_mem[st_r[ADDR_ST].addr0] <= st_r[ADDR_ST].lidx;
      end
      rd0_r <= lvl_mem[st_r[ADDR_ST].addr0];
      rd1_r <= lvl_mem[st_r[ADDR_ST].addr1];
    end
  end

  assign in_item.ready     = stage_free[0];
  assign out_item.valid    = vld_r[OUT_ST];
  assign out_item.modifier = st_r[OUT_ST].modifier;

  `ASSERT_IMPLIES(a_stall_means_full, clk, rst_n, !in_item.ready, &vld_r)
  `ASSERT_IMPLIES(a_rem_below_len, clk, rst_n, vld_r[MODL] && (st_r[MODL].op == OP_EVAL) && !st_r[MODL].special, st_r[MODL].rem < st_r[MODL].len)
  `ASSERT_IMPLIES(a_modifier_bound, clk, rst_n, out_item.valid, out_item.modifier <= LEVEL_PEAK)
  `ASSERT_NEXT(a_special_is_one, clk, rst_n, vld_r[MIX_ST] && st_r[MIX_ST].special && stage_free[OUT_ST], out_item.modifier == LEVEL_ONE)

endmodule

### dv/lpbs_checker.sv
module lpbs_checker import lpbs_pkg::*; #(
  parameter int STYLES  = 16,
  parameter int PAT_MAX = 64
) (
  input  logic clk,
  input  logic rst_n,
  lpbs_in_if   in_mon,
  lpbs_out_if  out_mon,
  input  logic drain_done,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LETTER_W-1:0] letters [STYLES][PAT_MAX];
  logic [6:0]          style_len [STYLES];
  logic [RATE_W-1:0]   style_rate [STYLES];
  logic                style_blend [STYLES];

  logic [MOD_W-1:0] level_q [$];
  int unsigned      shown;
  logic             drain_checked;

  function automatic logic [LETTER_W-1:0] letter_index(input logic [7:0] raw);
    if (raw < CHAR_A) return '0;
    if (raw > CHAR_Z) return LETTER_MAX;
    return LETTER_W'(raw - CHAR_A);
  endfunction

  // Brightness of a style at a time, in 1/65536 units.
  function automatic logic [MOD_W-1:0] level_for(input logic [7:0] sty,
                                                 input logic [TIME_W-1:0] t);
    logic [63:0] prod;
    logic [63:0] frame;
    logic [7:0]  frac;
    int unsigned n, p0, p1, i0, i1, step;
    if (sty >= STYLES || style_len[sty] == 0) return LEVEL_ONE;
    n     = style_len[sty];
    step  = LEVEL_STEP;
    prod  = 64'(t) * 64'(style_rate[sty]);
    frame = prod >> 24;
    frac  = prod[23:16];
    p0    = int'(frame % 64'(n));
    p1    = int'((frame + 64'd1) % 64'(n));
    i0    = letters[sty][p0];
    i1    = letters[sty][p1];
    if (style_blend[sty])
      return MOD_W'(step * (i0 * (256 - frac) + i1 * frac));
    return MOD_W'(step * 256 * i0);
  endfunction

  task automatic note_bad(input int unsigned amount, input string what);
    fail_count += amount;
    if (shown < 10) begin
      shown++;
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [MOD_W-1:0] want;
    if (!rst_n) begin
      for (int s = 0; s < STYLES; s++) begin
        style_len[s]   = '0;
        style_rate[s]  = '0;
        style_blend[s] = 1'b0;
        for (int p = 0; p < PAT_MAX; p++) letters[s][p] = '0;
      end
      level_q.delete();
      fail_count    = 0;
      shown         = 0;
      drain_checked = 1'b0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        case (op_t'(in_mon.op))
          OP_WRITE: begin
            if (in_mon.style < STYLES && in_mon.position < PAT_MAX)
              letters[in_mon.style][in_mon.position] = letter_index(in_mon.letter);
          end
          OP_HEADER: begin
            if (in_mon.style < STYLES) begin
              style_len[in_mon.style] = (in_mon.pattern_length > PAT_MAX) ?
                                        7'(PAT_MAX) : in_mon.pattern_length;
              style_rate[in_mon.style]  = in_mon.frame_rate;
              style_blend[in_mon.style] = in_mon.blend;
            end
          end
          OP_EVAL: level_q.push_back(level_for(in_mon.style, in_mon.time_req));
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (level_q.size() == 0) begin
          note_bad(1, $sformatf("modifier %0d arrived with nothing outstanding",
                                out_mon.modifier));
        end else begin
          want = level_q.pop_front();
          if (out_mon.modifier !== want)
            note_bad(1, $sformatf("modifier expected %0d got %0d", want,
                                  out_mon.modifier));
        end
      end
      if (drain_done && !drain_checked) begin
        drain_checked = 1'b1;
        if (level_q.size() != 0)
          note_bad(level_q.size(), $sformatf("%0d modifiers never arrived",
                                             level_q.size()));
      end
    end
    pending_count = level_q.size();
  end

endmodule

### dv/tb_light_pattern_brightness_sequencer.sv
module tb_light_pattern_brightness_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import lpbs_pkg::*;

  localparam int STYLES  = 16;
  localparam int PAT_MAX = 64;

  typedef struct packed {
    op_t               op;
    logic [7:0]        style;
    logic [5:0]        position;
    logic [7:0]        letter;
    logic [6:0]        pattern_length;
    logic [RATE_W-1:0] frame_rate;
    logic              blend;
    logic [TIME_W-1:0] time_req;
  } lamp_req_t;

  logic clk;
  logic rst_n;
  logic drain_done;
  int   fail_count;
  int   pending_count;

  lpbs_in_if  in_ch ();
  lpbs_out_if out_ch ();

  light_pattern_brightness_sequencer #(
    .STYLE_COUNT (STYLES),
    .PATTERN_MAX (PAT_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  lpbs_checker #(
    .STYLES  (STYLES),
    .PAT_MAX (PAT_MAX)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .drain_done    (drain_done),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Positions known to hold a written letter, per style.
  logic [PAT_MAX-1:0] written [STYLES];
  int unsigned        live_items;
  bit                 send_burst;

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(CHAR_A, CHAR_Z));
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0: return TIME_W'($urandom_range(0, 65535));
      1: return TIME_W'($urandom);
      default: return TIME_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return RATE_W'($urandom_range(1, 2048));
      default: return RATE_W'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_len();
    case ($urandom_range(0, 19))
      0, 1: return '0;
      2: return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic lamp_req_t noise_req();
    lamp_req_t r;
    r.op             = op_t'($urandom_range(0, 3));
    r.style          = 8'($urandom);
    r.position       = 6'($urandom);
    r.letter         = 8'($urandom);
    r.pattern_length = 7'($urandom);
    r.frame_rate     = RATE_W'($urandom);
    r.blend          = 1'($urandom);
    r.time_req       = TIME_W'({$urandom, $urandom});
    return r;
  endfunction

  // Called and returns at a falling edge; leaves valid high after the item.
  task automatic drive_req(input lamp_req_t r);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op             <= r.op;
    in_ch.style          <= r.style;
    in_ch.position       <= r.position;
    in_ch.letter         <= r.letter;
    in_ch.pattern_length <= r.pattern_length;
    in_ch.frame_rate     <= r.frame_rate;
    in_ch.blend          <= r.blend;
    in_ch.time_req       <= r.time_req;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (r.op == OP_EVAL || (r.op != OP_IDLE && r.style < STYLES)) live_items++;
  endtask

  task automatic put_letter(input logic [7:0] sty, input logic [5:0] pos,
                            input logic [7:0] raw);
    lamp_req_t r;
    r          = noise_req();
    r.op       = OP_WRITE;
    r.style    = sty;
    r.position = pos;
    r.letter   = raw;
    drive_req(r);
    if (sty < STYLES) written[sty][pos] = 1'b1;
  endtask

  // Fill any unwritten letter inside the new length before the header lands.
  task automatic set_style(input logic [7:0] sty, input logic [6:0] len,
                           input logic [RATE_W-1:0] rate, input logic bl);
    lamp_req_t   r;
    int unsigned span;
    if (sty < STYLES) begin
      span = (len > PAT_MAX) ? PAT_MAX : len;
      for (int p = 0; p < span; p++)
        if (!written[sty][p]) put_letter(sty, 6'(p), pick_letter());
    end
    r                = noise_req();
    r.op             = OP_HEADER;
    r.style          = sty;
    r.pattern_length = len;
    r.frame_rate     = rate;
    r.blend          = bl;
    drive_req(r);
  endtask

  task automatic ask_level(input logic [7:0] sty, input logic [TIME_W-1:0] t);
    lamp_req_t r;
    r          = noise_req();
    r.op       = OP_EVAL;
    r.style    = sty;
    r.time_req = t;
    drive_req(r);
  endtask

  // Result side: random stalls, plus one long hold-off to back the pipeline up.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    bit          sink_burst;
    out_ch.ready = 1'b0;
    taken        = 0;
    sink_burst   = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 8);
      if (taken == 300) stall = 400;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    lamp_req_t   r;
    int unsigned sel;
    int unsigned n;
    logic [7:0]  sty;
    bit          drained_once;

    rst_n                = 1'b0;
    drain_done           = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_IDLE;
    in_ch.style          = '0;
    in_ch.position       = '0;
    in_ch.letter         = '0;
    in_ch.pattern_length = '0;
    in_ch.frame_rate     = '0;
    in_ch.blend          = 1'b0;
    in_ch.time_req       = '0;
    live_items           = 0;
    send_burst           = 1'b0;
    drained_once         = 1'b0;
    for (int s = 0; s < STYLES; s++) written[s] = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty and absent styles, unused op, letter clamping, rates.
    ask_level(8'd0, '1);
    ask_level(8'hFF, '1);
    r    = noise_req();
    r    = '1;
    r.op = OP_IDLE;
    drive_req(r);
    put_letter(8'd0, 6'd0, 8'h00);
    put_letter(8'd0, 6'd1, 8'hFF);
    put_letter(8'd0, 6'd2, CHAR_A);
    put_letter(8'd0, 6'd3, CHAR_Z);
    put_letter(8'd0, 6'd62, CHAR_A - 8'd1);
    put_letter(8'd0, 6'd63, CHAR_Z + 8'd1);
    set_style(8'd0, 7'd4, '0, 1'b1);
    ask_level(8'd0, '1);
    set_style(8'd0, 7'd4, '1, 1'b1);
    ask_level(8'd0, '1);
    ask_level(8'd0, 48'h0000_0000_8000);
    ask_level(8'd0, '0);
    set_style(8'd0, 7'd4, 16'h0100, 1'b0);
    ask_level(8'd0, 48'h0000_0001_0000);
    set_style(8'd0, 7'd1, 16'h0100, 1'b0);
    ask_level(8'd0, 48'h0000_0003_0000);
    put_letter(8'd16, 6'd0, CHAR_Z);
    set_style(8'd200, 7'd5, 16'h0100, 1'b1);
    ask_level(8'd16, '0);
    set_style(8'd1, 7'd127, 16'h0100, 1'b1);
    ask_level(8'd1, '1);

    while (live_items < 1500) begin
      // Pause the source once until everything outstanding has come back.
      if (!drained_once && live_items > 700) begin
        drained_once = 1'b1;
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
      end
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        sty = 8'($urandom_range(0, STYLES - 1));
        n   = $urandom_range(0, 4);
        repeat (n) put_letter(sty, 6'($urandom), pick_letter());
        set_style(sty, pick_len(), pick_rate(), 1'($urandom));
        n = $urandom_range(2, 8);
        repeat (n) ask_level(sty, pick_time());
      end else if (sel < 17) begin
        ask_level(8'($urandom_range(0, STYLES - 1)), pick_time());
      end else if (sel == 17) begin
        ask_level(8'($urandom_range(STYLES, 255)), pick_time());
      end else if (sel == 18) begin
        r       = noise_req();
        r.style = 8'($urandom_range(STYLES, 255));
        drive_req(r);
      end else begin
        put_letter(8'($urandom_range(0, STYLES - 1)), 6'($urandom), pick_letter());
      end
    end

    in_ch.valid <= 1'b0;
    for (n = 0; n < 100000 && pending_count != 0; n++) @(negedge clk);
    repeat (20) @(negedge clk);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
